// File: hdl/rid_pkg.sv
// Shared types and constants for the reciprocal integer divider.
package rid_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Operation codes carried on the request channel
    typedef enum logic [1:0] {
        OP_UDIV = 2'd0,
        OP_UREM = 2'd1,
        OP_SDIV = 2'd2,
        OP_SREM = 2'd3
    } t_opcode;

    // Control word that travels with each request down the cell chain
    typedef struct packed {
        logic valid;     // stage holds a live request
        logic is_rem;    // deliver remainder instead of quotient
        logic neg_q;     // quotient must be negated at the end
        logic neg_r;     // remainder must be negated at the end
        logic div_zero;  // divisor was zero
    } t_ctl;

endpackage

// File: hdl/rid_ifs.sv
// Request and response channel interfaces of the reciprocal integer divider.
interface rid_req_if #(
    parameter int W = rid_pkg::DATA_WIDTH_DEFAULT
);
    logic         valid;
    logic         ready;
    logic [1:0]   opcode;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;

    modport source (output valid, opcode, dividend, divisor, input ready);
    modport sink   (input valid, opcode, dividend, divisor, output ready);
endinterface

interface rid_rsp_if #(
    parameter int W = rid_pkg::DATA_WIDTH_DEFAULT
);
    logic         valid;
    logic         ready;
    logic [W-1:0] result_value;
    logic         divide_by_zero;

    modport source (output valid, result_value, divide_by_zero, input ready);
    modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

// File: hdl/rid_prep.sv
// Input stage: decodes the opcode and takes operand magnitudes.
module rid_prep #(
    parameter int W = rid_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    rid_req_if.sink        i_req,
    output rid_pkg::t_ctl  o_ctl,
    output logic [W-1:0]   o_nm,
    output logic [W-1:0]   o_dm
);

    rid_pkg::t_opcode w_op;
    logic             w_signed;
    logic             w_is_rem;
    logic             w_nneg;
    logic             w_dneg;
    rid_pkg::t_ctl    n_ctl;
    logic [W-1:0]     n_nm;
    logic [W-1:0]     n_dm;
    rid_pkg::t_ctl    r_ctl;
    logic [W-1:0]     r_nm;
    logic [W-1:0]     r_dm;

    assign w_op = rid_pkg::t_opcode'(i_req.opcode);

    // Opcode decode
    always_comb begin
        unique case (w_op)
            rid_pkg::OP_UDIV: begin w_signed = 1'b0; w_is_rem = 1'b0; end
            rid_pkg::OP_UREM: begin w_signed = 1'b0; w_is_rem = 1'b1; end
            rid_pkg::OP_SDIV: begin w_signed = 1'b1; w_is_rem = 1'b0; end
            rid_pkg::OP_SREM: begin w_signed = 1'b1; w_is_rem = 1'b1; end
            default:          begin w_signed = 1'b0; w_is_rem = 1'b0; end
        endcase
    end

    // Sign handling: signed ops divide magnitudes
    assign w_nneg = w_signed & i_req.dividend[W-1];
    assign w_dneg = w_signed & i_req.divisor[W-1];
    assign n_nm   = w_nneg ? (~i_req.dividend + W'(1)) : i_req.dividend;
    assign n_dm   = w_dneg ? (~i_req.divisor + W'(1)) : i_req.divisor;

    always_comb begin
        n_ctl          = '0;
        n_ctl.valid    = i_req.valid;
        n_ctl.is_rem   = w_is_rem;
        n_ctl.neg_q    = w_nneg ^ w_dneg;
        n_ctl.neg_r    = w_nneg;
        n_ctl.div_zero = (i_req.divisor == '0);
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm <= n_nm;
            r_dm <= n_dm;
        end
    end

    assign o_ctl = r_ctl;
    assign o_nm  = r_nm;
    assign o_dm  = r_dm;

endmodule

// File: hdl/rid_cell.sv
// One restoring-division cell: settles one quotient bit per request.
module rid_cell #(
    parameter int W = rid_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  rid_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]   i_rem,
    input  logic [W-1:0]   i_nq,
    input  logic [W-1:0]   i_dm,
    output rid_pkg::t_ctl  o_ctl,
    output logic [W-1:0]   o_rem,
    output logic [W-1:0]   o_nq,
    output logic [W-1:0]   o_dm
);

    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_ge;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_nq;
    rid_pkg::t_ctl r_ctl;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_nq;
    logic [W-1:0]  r_dm;

    // Shift next dividend bit into the remainder, trial subtract
    assign w_trial = {i_rem, i_nq[W-1]};
    assign w_diff  = w_trial - {1'b0, i_dm};
    assign w_ge    = (w_trial >= {1'b0, i_dm});
    assign n_rem   = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
    // Dividend bits leave at the top, quotient bits enter at the bottom
    assign n_nq    = {i_nq[W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_dm  <= i_dm;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_dm  = r_dm;

endmodule

// File: hdl/rid_post.sv
// Output stage: restores signs, applies the zero-divisor convention, holds the result.
module rid_post #(
    parameter int W = rid_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rid_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]   i_rem,
    input  logic [W-1:0]   i_quo,
    output logic           o_en,
    rid_rsp_if.source      o_rsp
);

    logic [W-1:0] w_q;
    logic [W-1:0] w_r;
    logic [W-1:0] n_result;
    logic         r_valid;
    logic [W-1:0] r_result;
    logic         r_dz;

    // Pipeline advances whenever the output register is free or being taken
    assign o_en = !r_valid || o_rsp.ready;

    // Sign restore; a zero divisor forces an all-ones quotient
    assign w_q = i_ctl.div_zero ? '1 : (i_ctl.neg_q ? (~i_quo + W'(1)) : i_quo);
    assign w_r = i_ctl.neg_r ? (~i_rem + W'(1)) : i_rem;
    assign n_result = i_ctl.is_rem ? w_r : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_result <= n_result;
            r_dz     <= i_ctl.div_zero;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.result_value   = r_result;
    assign o_rsp.divide_by_zero = r_dz;

endmodule

// File: hdl/reciprocal_integer_divider_unit.sv
// Top level of the reciprocal integer divider: input stage, cell chain, output stage.
//
// Usage:
//   i_req carries opcode (unsigned div, unsigned rem, signed div, signed rem),
//   dividend and divisor; o_rsp returns result_value and divide_by_zero.
//   A request moves on a rising edge with valid and ready both high.
//   The pipeline has one input stage, one restoring-division cell per
//   quotient bit and one output register. Throughput is one request per
//   cycle while the receiver does not stall; the chain of DATA_WIDTH cells
//   is fully pipelined, each cell doing one subtract and compare.
//   Signed operations divide magnitudes; the quotient truncates toward zero
//   and the remainder takes the dividend's sign. The most negative value
//   divided by minus one wraps to itself. A zero divisor raises
//   divide_by_zero, gives an all-ones quotient and returns the dividend as
//   the remainder.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and i_req.ready drops; it rises again once the result is taken.
//   Synchronous reset empties every stage; no results are pending after it.
module reciprocal_integer_divider_unit #(
    parameter int DATA_WIDTH = rid_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rid_req_if.sink    i_req,
    rid_rsp_if.source  o_rsp
);

    logic          w_en;
    rid_pkg::t_ctl w_ctl [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_nq  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] w_dm  [DATA_WIDTH+1];

    assign i_req.ready = w_en;
    // Partial remainder starts at zero
    assign w_rem[0] = '0;

    // Operand decode and magnitudes
    rid_prep #(.W(DATA_WIDTH)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (i_req),
        .o_ctl   (w_ctl[0]),
        .o_nm    (w_nq[0]),
        .o_dm    (w_dm[0])
    );

    // Chain of division cells, one quotient bit each
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        rid_cell #(.W(DATA_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_nq    (w_nq[g]),
            .i_dm    (w_dm[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_nq    (w_nq[g+1]),
            .o_dm    (w_dm[g+1])
        );
    end

    // Sign restore and output register
    rid_post #(.W(DATA_WIDTH)) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[DATA_WIDTH]),
        .i_rem   (w_rem[DATA_WIDTH]),
        .i_quo   (w_nq[DATA_WIDTH]),
        .o_en    (w_en),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    // Final remainder magnitude is below the divisor magnitude
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[DATA_WIDTH].valid && !w_ctl[DATA_WIDTH].div_zero
        |-> w_rem[DATA_WIDTH] < w_dm[DATA_WIDTH])
        else $error("remainder not below divisor at end of cell chain");

    // Zero divisor leaves all quotient bits set at the end of the chain
    a_dz_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[DATA_WIDTH].valid && w_ctl[DATA_WIDTH].div_zero
        |-> (&w_nq[DATA_WIDTH]))
        else $error("zero divisor did not give all-ones quotient");

    // An accepted request occupies the input stage on the next cycle
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> w_ctl[0].valid)
        else $error("accepted request lost at input stage");
`endif

endmodule

// File: test/tb.sv
// Self-checking testbench for the reciprocal integer divider unit.

typedef logic [rid_pkg::DATA_WIDTH_DEFAULT-1:0] t_word;

// One expected response, along with the request that caused it
typedef struct packed {
    rid_pkg::t_opcode op;
    t_word            dividend;
    t_word            divisor;
    t_word            value;
    logic             dz;
} t_div_outcome;

// Predicts each accepted request and matches responses in order
class division_checker;
    t_div_outcome pending_outcomes[$];
    int           errors = 0;

    // Exact division on magnitudes, signs restored afterwards
    function t_div_outcome exact_divide(rid_pkg::t_opcode op, t_word n, t_word d);
        t_div_outcome o;
        logic         is_signed;
        logic         n_neg;
        logic         d_neg;
        t_word        n_mag;
        t_word        d_mag;
        t_word        q;
        t_word        r;
        o.op       = op;
        o.dividend = n;
        o.divisor  = d;
        o.dz       = 1'b0;
        // Zero divisor: all ones for divides, dividend for remainders
        if (d == '0) begin
            o.dz    = 1'b1;
            o.value = (op == rid_pkg::OP_UREM || op == rid_pkg::OP_SREM) ? n : '1;
            return o;
        end
        is_signed = (op == rid_pkg::OP_SDIV || op == rid_pkg::OP_SREM);
        n_neg     = is_signed && n[$bits(t_word)-1];
        d_neg     = is_signed && d[$bits(t_word)-1];
        n_mag     = n_neg ? -n : n;
        d_mag     = d_neg ? -d : d;
        q         = n_mag / d_mag;
        r         = n_mag % d_mag;
        if (op == rid_pkg::OP_UDIV || op == rid_pkg::OP_SDIV) begin
            o.value = (n_neg ^ d_neg) ? -q : q;
        end else begin
            o.value = n_neg ? -r : r;
        end
        return o;
    endfunction

    // Queue the expected response at the tail
    function void note_request(rid_pkg::t_opcode op, t_word n, t_word d);
        t_div_outcome o;
        o = exact_divide(op, n, d);
        pending_outcomes = {pending_outcomes, o};
    endfunction

    function int pending();
        return pending_outcomes.size();
    endfunction

    task report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_response(input t_word value, input logic dz);
        t_div_outcome want;
        if (pending_outcomes.size() == 0) begin
            report($sformatf("response %h dz=%0b with no request outstanding", value, dz));
            return;
        end
        want = pending_outcomes.pop_front();
        if (value !== want.value) begin
            report($sformatf("%s %h / %h: result %h, expected %h", want.op.name(),
                             want.dividend, want.divisor, value, want.value));
        end
        if (dz !== want.dz) begin
            report($sformatf("%s %h / %h: divide_by_zero %b, expected %b", want.op.name(),
                             want.dividend, want.divisor, dz, want.dz));
        end
    endtask
endclass

module tb;

    localparam int    W              = rid_pkg::DATA_WIDTH_DEFAULT;
    localparam int    DRAIN_CYCLES   = W + 8;
    localparam int    HOLDOFF_CYCLES = 300;
    localparam int    STALL_LIMIT    = 5000;
    localparam t_word INT_MIN        = {1'b1, {(W-1){1'b0}}};
    localparam t_word INT_MAX        = {1'b0, {(W-1){1'b1}}};
    localparam t_word ALL_ONES       = '1;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic holdoff_start;
    int   quiet_cycles;

    division_checker board = new();

    rid_req_if #(.W(W)) req_bus ();
    rid_rsp_if #(.W(W)) rsp_bus ();

    reciprocal_integer_divider_unit #(
        .DATA_WIDTH(W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: ends the run when neither channel moves for too long
    initial quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response side: check on acceptance, then pick ready for the next cycle
    initial begin
        int holdoff_left;
        holdoff_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                board.check_response(rsp_bus.result_value, rsp_bus.divide_by_zero);
            end
            if (holdoff_start) begin
                holdoff_left  = HOLDOFF_CYCLES;
                holdoff_start = 1'b0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_request(input rid_pkg::t_opcode op, input t_word n, input t_word d);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.opcode   <= op;
        req_bus.dividend <= n;
        req_bus.divisor  <= d;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        board.note_request(op, n, d);
    endtask

    // Stop offering and wait for every outstanding response
    task automatic hold_until_results_drained();
        req_bus.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Operands biased toward boundary values and short magnitudes
    function automatic t_word pick_operand();
        t_word v;
        case ($urandom_range(9))
            0:       v = INT_MIN;
            1:       v = ALL_ONES;
            2:       v = INT_MAX;
            3:       v = t_word'(1);
            4, 5:    v = $urandom() >> $urandom_range(W-1);
            6:       v = -($urandom() >> $urandom_range(W-1));
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        rid_pkg::t_opcode op;
        t_word            n;
        t_word            d;
        repeat (count) begin
            op = rid_pkg::t_opcode'($urandom_range(3));
            n  = pick_operand();
            d  = ($urandom_range(99) < 4) ? '0 : pick_operand();
            send_request(op, n, d);
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.opcode   = rid_pkg::OP_UDIV;
        req_bus.dividend = '0;
        req_bus.divisor  = '0;
        rsp_bus.ready    = 1'b0;
        holdoff_start    = 1'b0;
        tx_idle_pct      = 25;
        rx_idle_pct      = 52;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every opcode, sign combinations, overflow, zero divisor
        send_request(rid_pkg::OP_UDIV, ALL_ONES, t_word'(1));
        send_request(rid_pkg::OP_UDIV, ALL_ONES, ALL_ONES);
        send_request(rid_pkg::OP_UDIV, '0, ALL_ONES);
        send_request(rid_pkg::OP_UDIV, t_word'(100), t_word'(7));
        send_request(rid_pkg::OP_UREM, ALL_ONES, t_word'(32'h0001_0000));
        send_request(rid_pkg::OP_UREM, t_word'(5), t_word'(7));
        send_request(rid_pkg::OP_UREM, INT_MIN, t_word'(3));
        send_request(rid_pkg::OP_SDIV, -t_word'(7), t_word'(2));
        send_request(rid_pkg::OP_SDIV, t_word'(7), -t_word'(2));
        send_request(rid_pkg::OP_SDIV, -t_word'(7), -t_word'(2));
        send_request(rid_pkg::OP_SREM, -t_word'(7), t_word'(2));
        send_request(rid_pkg::OP_SREM, t_word'(7), -t_word'(2));
        send_request(rid_pkg::OP_SDIV, INT_MIN, ALL_ONES);
        send_request(rid_pkg::OP_SREM, INT_MIN, ALL_ONES);
        send_request(rid_pkg::OP_SDIV, INT_MIN, t_word'(1));
        send_request(rid_pkg::OP_SDIV, INT_MAX, INT_MIN);
        send_request(rid_pkg::OP_SREM, INT_MAX, INT_MIN);
        send_request(rid_pkg::OP_SREM, INT_MIN, INT_MIN);
        send_request(rid_pkg::OP_UDIV, t_word'(12345), '0);
        send_request(rid_pkg::OP_UREM, t_word'(32'hDEAD_BEEF), '0);
        send_request(rid_pkg::OP_SDIV, INT_MIN, '0);
        send_request(rid_pkg::OP_SREM, -t_word'(7), '0);
        send_request(rid_pkg::OP_UDIV, '0, '0);
        hold_until_results_drained();

        // Random, sender mostly busy, receiver stalling often
        run_random(195);

        // Random, sender idling often, receiver mostly ready
        tx_idle_pct = 52;
        rx_idle_pct = 25;
        run_random(195);
        hold_until_results_drained();

        // Random at full rate, opening with a long receiver hold-off to fill the pipe
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        holdoff_start = 1'b1;
        run_random(195);
        hold_until_results_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
